// ===== rtl/core/hcc_pkg.sv =====
// hcc_pkg: shared types, constants and helpers for the hex color classifier
// no dependencies; imported by hex_color_classifier

package hcc_pkg;

   localparam int unsigned DIGIT_W      = 8;
   localparam int unsigned NUM_DIGITS   = 6;
   localparam int unsigned COUNT_W      = 3;
   localparam int unsigned COMP_W       = 8;
   localparam int unsigned NIBBLE_W     = 4;
   localparam int unsigned LUMA_W       = 16;
   localparam int unsigned TALLY_W      = 16;
   localparam int unsigned NUM_NAMED    = 7;
   localparam int unsigned CLASS_W      = 3;

   localparam int unsigned REQ_FIELDS_W = NUM_DIGITS * DIGIT_W + COUNT_W;
   localparam int unsigned REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int unsigned RSP_FIELDS_W = 3 * COMP_W + CLASS_W + LUMA_W + TALLY_W;
   localparam int unsigned RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [COMP_W-1:0]  MARGIN_RESET = 8'd30;
   localparam logic [TALLY_W-1:0] TALLY_MAX    = 16'hFFFF;

   // BT.601 weights scaled by 256
   localparam logic [7:0] LUMA_KR = 8'd77;
   localparam logic [7:0] LUMA_KG = 8'd150;
   localparam logic [7:0] LUMA_KB = 8'd29;

   // digit counts with a meaning of their own
   localparam logic [COUNT_W-1:0] CNT_FULL      = 3'd6;
   localparam logic [COUNT_W-1:0] CNT_SHORT_MIN = 3'd3;
   localparam logic [COUNT_W-1:0] CNT_SHORT_MAX = 3'd5;

   typedef enum logic [CLASS_W-1:0] {
      CLS_GREY      = 3'd0,
      CLS_RED       = 3'd1,
      CLS_GREEN     = 3'd2,
      CLS_BLUE      = 3'd3,
      CLS_PURPLE    = 3'd4,
      CLS_TURQUOISE = 3'd5,
      CLS_YELLOW    = 3'd6,
      CLS_BLENDED   = 3'd7
   } color_class_type;

   typedef struct packed {
      logic                ok;
      logic [NIBBLE_W-1:0] val;
   } hex_digit_type;

   // ascii hex character to nibble, ok low for anything else
   function automatic hex_digit_type hex_decode(input logic [DIGIT_W-1:0] c);
      hex_digit_type h;
      h.ok  = 1'b1;
      h.val = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.val = NIBBLE_W'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.val = NIBBLE_W'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.val = NIBBLE_W'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
                                                  input logic [COMP_W-1:0] b);
      return (a >= b) ? COMP_W'(a - b) : COMP_W'(b - a);
   endfunction

endpackage

// ===== rtl/core/hex_color_classifier.sv =====
// hex_color_classifier: decodes an ascii hex color code, classifies it and counts classes
// depends on hcc_pkg (types, constants, hex decode helper)

// Takes one color code per transaction and returns one result per transaction, in order.
// An accepted code lands in an input register; the decode, the classification, the luma
// multiply-add and the saturating class count update happen combinationally on the way
// into the result register, so while the result side is not stalled a transaction can enter
// every cycle and its result is driven from the result register. Throughput is then
// one transaction per cycle; the only state carried from one transaction to the next is the
// class count bank, updated as a transaction moves into the result register. Invalid codes
// (bad digit, bad digit count or a zero component) come out with rsp_tuser low, class
// blended and all other fields zero, and leave the counts alone. csr_wr_data sets the
// difference margin (reset 30) and is meant to be written while no transaction is in flight.

module hex_color_classifier
   import hcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_wr_en,
   input  logic [COMP_W-1:0]     csr_wr_data,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   // digit_0 [7:0], digit_1 [15:8], digit_2 [23:16], digit_3 [31:24],
   // digit_4 [39:32], digit_5 [47:40], digit_count [50:48], zero fill above
   input  logic [REQ_DATA_W-1:0] req_tdata,

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // red [7:0], green [15:8], blue [23:16], color_class [26:24],
   // luma_q8_8 [42:27], class_tally [58:43], zero fill above
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // valid_res [0]
   output logic                  rsp_tuser
);

   logic [COMP_W-1:0]                  margin_ff;
   logic                               s1_valid_ff;
   logic [REQ_FIELDS_W-1:0]            s1_data_ff;
   logic                               rsp_valid_ff;
   logic [RSP_DATA_W-1:0]              rsp_data_ff;
   logic                               rsp_user_ff;
   logic [NUM_NAMED-1:0][TALLY_W-1:0]  class_counts_ff;
   logic [NUM_NAMED-1:0][TALLY_W-1:0]  class_counts_in;

   logic                               advance;
   logic                               req_take;
   hex_digit_type [NUM_DIGITS-1:0]     hd;
   logic [COUNT_W-1:0]                 dcount;
   logic [COMP_W-1:0]                  red, green, blue;
   logic                               comp_ok;
   logic                               code_valid;
   logic [COMP_W-1:0]                  d_rg, d_rb, d_gb;
   logic [COMP_W:0]                    r_x, g_x, b_x, m_x;
   color_class_type                    cls;
   logic [LUMA_W-1:0]                  luma;
   logic [TALLY_W-1:0]                 tally_cur;
   logic [TALLY_W-1:0]                 tally_new;
   logic                               count_en;
   logic [RSP_DATA_W-1:0]              rsp_data_in;

   // handshake: the input register frees up when its transaction moves on
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
      end else if (csr_wr_en) begin
         margin_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_tdata[REQ_FIELDS_W-1:0];
      end
   end

   // digit decode and component assembly
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         hd[i] = hex_decode(s1_data_ff[i*DIGIT_W +: DIGIT_W]);
      end
      dcount  = s1_data_ff[NUM_DIGITS*DIGIT_W +: COUNT_W];
      red     = '0;
      green   = '0;
      blue    = '0;
      comp_ok = 1'b0;
      unique case (dcount) inside
         CNT_FULL: begin
            red     = {hd[0].val, hd[1].val};
            green   = {hd[2].val, hd[3].val};
            blue    = {hd[4].val, hd[5].val};
            comp_ok = hd[0].ok && hd[1].ok && hd[2].ok && hd[3].ok && hd[4].ok && hd[5].ok;
         end
         [CNT_SHORT_MIN:CNT_SHORT_MAX]: begin
            // short form: single digits, not scaled
            red     = {{(COMP_W-NIBBLE_W){1'b0}}, hd[0].val};
            green   = {{(COMP_W-NIBBLE_W){1'b0}}, hd[1].val};
            blue    = {{(COMP_W-NIBBLE_W){1'b0}}, hd[2].val};
            comp_ok = hd[0].ok && hd[1].ok && hd[2].ok;
         end
         default: begin
            comp_ok = 1'b0;
         end
      endcase
      code_valid = comp_ok && (red != '0) && (green != '0) && (blue != '0);
   end

   // classification against the margin
   always_comb begin
      d_rg = abs_diff(red, green);
      d_rb = abs_diff(red, blue);
      d_gb = abs_diff(green, blue);
      r_x  = {1'b0, red};
      g_x  = {1'b0, green};
      b_x  = {1'b0, blue};
      m_x  = {1'b0, margin_ff};
      if ((red == green && red == blue) ||
          (d_rg < margin_ff && d_rb < margin_ff && d_gb < margin_ff)) begin
         cls = CLS_GREY;
      end else if (r_x > b_x + m_x && r_x > g_x + m_x) begin
         cls = CLS_RED;
      end else if (g_x > r_x + m_x && g_x > b_x + m_x) begin
         cls = CLS_GREEN;
      end else if (b_x > r_x + m_x && b_x > g_x + m_x) begin
         cls = CLS_BLUE;
      end else if (d_rb < d_gb && blue > green && red > green) begin
         cls = CLS_PURPLE;
      end else if (d_gb < d_rb && blue > red && green > red) begin
         cls = CLS_TURQUOISE;
      end else if (d_rg < d_rb && green > blue && red > blue) begin
         cls = CLS_YELLOW;
      end else begin
         cls = CLS_BLENDED;
      end
   end

   // products widened first, the sum tops out at 65280
   assign luma = LUMA_W'(LUMA_KR) * LUMA_W'(red) +
                 LUMA_W'(LUMA_KG) * LUMA_W'(green) +
                 LUMA_W'(LUMA_KB) * LUMA_W'(blue);

   // saturating count of the named classes
   always_comb begin
      count_en        = advance && code_valid && (cls != CLS_BLENDED);
      tally_cur       = (cls != CLS_BLENDED) ? class_counts_ff[cls] : '0;
      tally_new       = (tally_cur == TALLY_MAX) ? tally_cur : TALLY_W'(tally_cur + 1'b1);
      class_counts_in = class_counts_ff;
      if (count_en) begin
         class_counts_in[cls] = tally_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_counts_ff <= '0;
      end else begin
         class_counts_ff <= class_counts_in;
      end
   end

   always_comb begin
      rsp_data_in = '0;
      if (code_valid) begin
         rsp_data_in[RSP_FIELDS_W-1:0] = {
            (cls != CLS_BLENDED) ? tally_new : {TALLY_W{1'b0}},
            luma, cls, blue, green, red};
      end else begin
         rsp_data_in[3*COMP_W +: CLASS_W] = CLS_BLENDED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= code_valid;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // the input side only stalls when the input register holds a transaction
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff)
      else $error("input stalled with empty input register");

   // an invalid or blended transaction leaves the counts untouched
   a_counts_hold: assert property (@(posedge clock) disable iff (reset)
      (advance && (!code_valid || cls == CLS_BLENDED)) |=> $stable(class_counts_ff))
      else $error("class counts changed on a non-counting transaction");

   // a pending named result reports the live count of its class
   a_tally_matches: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff &&
       rsp_data_ff[3*COMP_W +: CLASS_W] != CLS_BLENDED) |->
      (class_counts_ff[rsp_data_ff[3*COMP_W +: CLASS_W]] ==
       rsp_data_ff[3*COMP_W+CLASS_W+LUMA_W +: TALLY_W]))
      else $error("reported tally differs from stored count");

   // an accepted transaction always occupies the input register next cycle
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted transaction lost");

endmodule
